>>> design/mfs_pkg.sv
`default_nettype none

package mfs_pkg;

   localparam logic [7:0] SYNC_BYTE    = 8'hFF;
   localparam logic [7:0] SYNC_HI_MASK = 8'hF0;

   localparam logic [1:0] LAYER_ONE    = 2'd3;
   localparam logic [1:0] MODE_MONO    = 2'd3;
   localparam logic [1:0] CHAN_MONO    = 2'd1;
   localparam logic [1:0] CHAN_STEREO  = 2'd2;
   localparam logic [1:0] LAST_HDR_IDX = 2'd3;

   localparam int HEADER_BYTES = 4;
   localparam int LEN_W        = 14;
   localparam int LEN_CALC_W   = 15;
   localparam int RATE_W       = 16;
   localparam int TIME_W       = 32;
   localparam int TSTEP_W      = 7;
   localparam int BRK_W        = 9;
   localparam int DIVIDEND_W   = 26;
   localparam int QUO_W        = 12;
   localparam int DIV_STEP_W   = $clog2(DIVIDEND_W + 1);

   // Frame-length scale factors (12 and 144, times 1000) for the multiply by the kbps bit rate.
   localparam logic [DIVIDEND_W-1:0] SCALE_LAYER_ONE = 26'd12000;
   localparam logic [DIVIDEND_W-1:0] SCALE_OTHER     = 26'd144000;

   localparam logic [BRK_W-1:0] BITRATE_KBPS [2][3][16] = '{
      '{
         '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
         '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
         '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0}
      },
      '{
         '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
           9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
         '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
         '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
           9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0}
      }
   };

   localparam logic [RATE_W-1:0] BASE_RATE [4] = '{
      16'd22050, 16'd24000, 16'd16000, 16'd22050
   };

   // Rounded milliseconds per 1024-sample frame for each rate.
   localparam logic [TSTEP_W-1:0] TIME_STEP [2][4] = '{
      '{7'd46, 7'd43, 7'd64, 7'd46},
      '{7'd23, 7'd21, 7'd32, 7'd23}
   };

   typedef enum logic [1:0] {
      EMIT_BODY,
      EMIT_HEADER,
      EMIT_CUT
   } emit_sel_type;

   typedef struct packed {
      logic         wr_hold0;
      logic         wr_hold1;
      logic         wr_hold2;
      logic         wr_hold3;
      logic         start_div;
      logic         latch_frame;
      logic         clear_left;
      logic         dec_left;
      logic         emit;
      emit_sel_type emit_sel;
      logic [1:0]   hdr_idx;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_flush;
      logic is_sync;
      logic is_sync_hi;
      logic out_free;
      logic div_done;
      logic len_ok;
      logic left_zero;
      logic left_one;
   } dp_status_type;

   function automatic logic [BRK_W-1:0] bitrate_kbps(input logic ver,
                                                    input logic [1:0] row,
                                                    input logic [3:0] idx);
      return BITRATE_KBPS[ver][row][idx];
   endfunction

   function automatic logic [RATE_W-1:0] sample_rate_of(input logic ver,
                                                       input logic [1:0] code);
      logic [RATE_W-1:0] base;
      base = BASE_RATE[code];
      return ver ? {base[RATE_W-2:0], 1'b0} : base;
   endfunction

endpackage

`default_nettype wire

>>> design/mfs_channels.sv
`default_nettype none

interface mfs_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] in_byte;

   modport source (output valid, output req_type, output in_byte, input ready);
   modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

interface mfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  frame_byte;
   logic        byte_valid;
   logic        frame_first;
   logic        frame_last;
   logic        frame_cut;
   logic [15:0] sample_rate;
   logic [1:0]  channel_count;
   logic [31:0] frame_time;
   logic [13:0] frame_length;
   logic        run_last;

   modport source (output valid, output frame_byte, output byte_valid,
                   output frame_first, output frame_last, output frame_cut,
                   output sample_rate, output channel_count, output frame_time,
                   output frame_length, output run_last, input ready);
   modport sink   (input valid, input frame_byte, input byte_valid,
                   input frame_first, input frame_last, input frame_cut,
                   input sample_rate, input channel_count, input frame_time,
                   input frame_length, input run_last, output ready);
endinterface

`default_nettype wire

>>> design/mfs_divider.sv
`default_nettype none

module mfs_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [mfs_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [mfs_pkg::RATE_W-1:0]      divisor,
   output logic                            done,
   output logic [mfs_pkg::DIVIDEND_W-1:0]  quotient
);
   import mfs_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [RATE_W-1:0]     rem_ff, rem_in;
   logic [RATE_W-1:0]     div_ff, div_in;
   logic [RATE_W:0]       shifted;
   logic [RATE_W:0]       diff;

   // Restoring division, one quotient bit per cycle, dividend shifted out of quo_ff.
   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = shifted - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_STEP_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (diff[RATE_W]) begin
            rem_in = shifted[RATE_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end else begin
            rem_in = diff[RATE_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - DIV_STEP_W'(1);
         if (cnt_ff == DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> design/mfs_datapath.sv
`default_nettype none

module mfs_datapath #(
   parameter int MAX_FRAME_BYTES = 16376
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mfs_pkg::ctl_cmd_type   cmd,
   output mfs_pkg::dp_status_type status,
   input  logic                   req_type,
   input  logic [7:0]             in_byte,
   input  logic                   out_ready,
   output logic                   out_valid,
   output logic [7:0]             frame_byte,
   output logic                   byte_valid,
   output logic                   frame_first,
   output logic                   frame_last,
   output logic                   frame_cut,
   output logic [15:0]            sample_rate,
   output logic [1:0]             channel_count,
   output logic [31:0]            frame_time,
   output logic [13:0]            frame_length,
   output logic                   run_last
);
   import mfs_pkg::*;

   logic [7:0]        hold0_ff, hold1_ff, hold2_ff, hold3_ff;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [1:0]        chan_ff, chan_in;
   logic [TIME_W-1:0] tcount_ff, tcount_in;
   logic [TIME_W-1:0] time_ff, time_in;

   logic              ovalid_ff, ovalid_in;
   logic [7:0]        obyte_ff, obyte_in;
   logic              obvalid_ff, obvalid_in;
   logic              ofirst_ff, ofirst_in;
   logic              olast_ff, olast_in;
   logic              ocut_ff, ocut_in;
   logic [RATE_W-1:0] orate_ff, orate_in;
   logic [1:0]        ochan_ff, ochan_in;
   logic [TIME_W-1:0] otime_ff, otime_in;
   logic [LEN_W-1:0]  olen_ff, olen_in;
   logic              orun_ff, orun_in;

   logic                  ver;
   logic [1:0]            layer;
   logic [1:0]            row;
   logic [BRK_W-1:0]      br_k;
   logic [DIVIDEND_W-1:0] dividend;
   logic [RATE_W-1:0]     rate;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] quotient;
   logic [LEN_CALC_W-1:0] len_base;
   logic [LEN_CALC_W-1:0] len_full;
   logic [7:0]            hdr_byte;
   logic                  out_free;

   // Header fields come from the held second and third bytes.
   always_comb begin
      ver      = hold1_ff[3];
      layer    = hold1_ff[2:1];
      row      = (layer == 2'd0) ? 2'd0 : layer - 2'd1;
      br_k     = bitrate_kbps(ver, row, hold2_ff[7:4]);
      dividend = DIVIDEND_W'(br_k) *
                 ((layer == LAYER_ONE) ? SCALE_LAYER_ONE : SCALE_OTHER);
      rate     = sample_rate_of(ver, hold2_ff[3:2]);
      len_base = LEN_CALC_W'(quotient[QUO_W-1:0]) + LEN_CALC_W'(hold2_ff[1]);
      len_full = (layer == LAYER_ONE) ? {len_base[LEN_CALC_W-3:0], 2'b00} : len_base;
   end

   mfs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .dividend (dividend),
      .divisor  (rate),
      .done     (div_done),
      .quotient (quotient)
   );

   assign out_free = !ovalid_ff || out_ready;

   always_comb begin
      status.is_flush   = req_type;
      status.is_sync    = (in_byte == SYNC_BYTE);
      status.is_sync_hi = ((in_byte & SYNC_HI_MASK) == SYNC_HI_MASK);
      status.out_free   = out_free;
      status.div_done   = div_done;
      status.len_ok     = (len_full <= LEN_CALC_W'(MAX_FRAME_BYTES)) &&
                          (len_full >= LEN_CALC_W'(HEADER_BYTES));
      status.left_zero  = (left_ff == '0);
      status.left_one   = (left_ff == LEN_W'(1));
   end

   always_comb begin
      left_in   = left_ff;
      len_in    = len_ff;
      rate_in   = rate_ff;
      chan_in   = chan_ff;
      tcount_in = tcount_ff;
      time_in   = time_ff;
      if (cmd.clear_left) begin
         left_in = '0;
      end else if (cmd.latch_frame) begin
         left_in = len_full[LEN_W-1:0] - LEN_W'(HEADER_BYTES);
      end else if (cmd.dec_left && !status.left_zero) begin
         left_in = left_ff - LEN_W'(1);
      end
      if (cmd.latch_frame) begin
         len_in    = len_full[LEN_W-1:0];
         rate_in   = rate;
         chan_in   = (hold3_ff[7:6] == MODE_MONO) ? CHAN_MONO : CHAN_STEREO;
         time_in   = tcount_ff;
         tcount_in = tcount_ff + TIME_W'(TIME_STEP[ver][hold2_ff[3:2]]);
      end
   end

   always_comb begin
      unique case (cmd.hdr_idx)
         2'd0: hdr_byte = hold0_ff;
         2'd1: hdr_byte = hold1_ff;
         2'd2: hdr_byte = hold2_ff;
         default: hdr_byte = hold3_ff;
      endcase
   end

   // One result beat is loaded per emit; the frame data travels with it.
   always_comb begin
      ovalid_in  = ovalid_ff && !out_ready;
      obyte_in   = obyte_ff;
      obvalid_in = obvalid_ff;
      ofirst_in  = ofirst_ff;
      olast_in   = olast_ff;
      ocut_in    = ocut_ff;
      orate_in   = orate_ff;
      ochan_in   = ochan_ff;
      otime_in   = otime_ff;
      olen_in    = olen_ff;
      orun_in    = orun_ff;
      if (cmd.emit) begin
         ovalid_in = 1'b1;
         orate_in  = rate_ff;
         ochan_in  = chan_ff;
         otime_in  = time_ff;
         olen_in   = len_ff;
         unique case (cmd.emit_sel)
            EMIT_BODY: begin
               obyte_in   = in_byte;
               obvalid_in = 1'b1;
               ofirst_in  = 1'b0;
               olast_in   = status.left_one;
               ocut_in    = 1'b0;
               orun_in    = 1'b1;
            end
            EMIT_HEADER: begin
               obyte_in   = hdr_byte;
               obvalid_in = 1'b1;
               ofirst_in  = (cmd.hdr_idx == 2'd0);
               olast_in   = (cmd.hdr_idx == LAST_HDR_IDX) && status.left_zero;
               ocut_in    = 1'b0;
               orun_in    = (cmd.hdr_idx == LAST_HDR_IDX);
            end
            default: begin
               obyte_in   = '0;
               obvalid_in = 1'b0;
               ofirst_in  = 1'b0;
               olast_in   = 1'b1;
               ocut_in    = 1'b1;
               orun_in    = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         len_ff    <= '0;
         rate_ff   <= '0;
         chan_ff   <= CHAN_STEREO;
         tcount_ff <= '0;
         time_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         left_ff   <= left_in;
         len_ff    <= len_in;
         rate_ff   <= rate_in;
         chan_ff   <= chan_in;
         tcount_ff <= tcount_in;
         time_ff   <= time_in;
         ovalid_ff <= ovalid_in;
      end
      if (cmd.wr_hold0) hold0_ff <= in_byte;
      if (cmd.wr_hold1) hold1_ff <= in_byte;
      if (cmd.wr_hold2) hold2_ff <= in_byte;
      if (cmd.wr_hold3) hold3_ff <= in_byte;
      obyte_ff   <= obyte_in;
      obvalid_ff <= obvalid_in;
      ofirst_ff  <= ofirst_in;
      olast_ff   <= olast_in;
      ocut_ff    <= ocut_in;
      orate_ff   <= orate_in;
      ochan_ff   <= ochan_in;
      otime_ff   <= otime_in;
      olen_ff    <= olen_in;
      orun_ff    <= orun_in;
   end

   assign out_valid     = ovalid_ff;
   assign frame_byte    = obyte_ff;
   assign byte_valid    = obvalid_ff;
   assign frame_first   = ofirst_ff;
   assign frame_last    = olast_ff;
   assign frame_cut     = ocut_ff;
   assign sample_rate   = orate_ff;
   assign channel_count = ochan_ff;
   assign frame_time    = otime_ff;
   assign frame_length  = olen_ff;
   assign run_last      = orun_ff;

endmodule

`default_nettype wire

>>> design/mfs_control.sv
`default_nettype none

module mfs_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  mfs_pkg::dp_status_type status,
   output mfs_pkg::ctl_cmd_type   cmd
);
   import mfs_pkg::*;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_SYNC1,
      ST_HDR2,
      ST_HDR3,
      ST_BODY,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic       in_phase;
   logic       accept;
   logic       flush;

   always_comb begin
      in_phase = (state_ff == ST_HUNT) || (state_ff == ST_SYNC1) ||
                 (state_ff == ST_HDR2) || (state_ff == ST_HDR3) ||
                 (state_ff == ST_BODY);
      in_ready = in_phase && status.out_free;
      accept   = in_valid && in_ready;
      flush    = status.is_flush;

      state_in       = state_ff;
      idx_in         = idx_ff;
      cmd            = '0;
      cmd.emit_sel   = EMIT_BODY;
      cmd.hdr_idx    = idx_ff;
      cmd.clear_left = accept && flush;

      unique case (state_ff)
         ST_HUNT: begin
            if (accept && !flush && status.is_sync) begin
               cmd.wr_hold0 = 1'b1;
               state_in     = ST_SYNC1;
            end
         end
         ST_SYNC1: begin
            if (accept) begin
               if (!flush && status.is_sync_hi) begin
                  cmd.wr_hold1 = 1'b1;
                  state_in     = ST_HDR2;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_HDR2: begin
            if (accept) begin
               if (flush) begin
                  state_in = ST_HUNT;
               end else begin
                  cmd.wr_hold2 = 1'b1;
                  state_in     = ST_HDR3;
               end
            end
         end
         ST_HDR3: begin
            if (accept) begin
               if (flush) begin
                  state_in = ST_HUNT;
               end else begin
                  cmd.wr_hold3  = 1'b1;
                  cmd.start_div = 1'b1;
                  state_in      = ST_DIVIDE;
               end
            end
         end
         ST_BODY: begin
            if (accept) begin
               cmd.emit = 1'b1;
               if (flush) begin
                  cmd.emit_sel = EMIT_CUT;
                  state_in     = ST_HUNT;
               end else begin
                  cmd.dec_left = 1'b1;
                  if (status.left_one) begin
                     state_in = ST_HUNT;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               if (status.len_ok) begin
                  cmd.latch_frame = 1'b1;
                  idx_in          = 2'd0;
                  state_in        = ST_EMIT;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = EMIT_HEADER;
               if (idx_ff == LAST_HDR_IDX) begin
                  state_in = status.left_zero ? ST_HUNT : ST_BODY;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         idx_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

>>> design/mp3_frame_splitter_unit.sv
`default_nettype none

// Channel    Direction  Beat carries
// req_chan   in         req_type (byte or flush), in_byte
// rsp_chan   out        frame_byte, marks, sample_rate, channel_count, frame_time,
//                       frame_length, run_last
//
// Payload bytes pass through a single output register; hunt bytes produce no output.
// The fourth header byte starts a 26-step shift-subtract divide; for a frame length
// in range, the four header beats then leave one per cycle while the receiver takes
// them, and req_chan.ready stays low from that byte until the last one is loaded.
// Reset is synchronous and needs no sweep; the block is ready on the next cycle.
// A stalled result holds the output register and req_chan.ready stays low meanwhile.

module mp3_frame_splitter_unit #(
   parameter int MAX_FRAME_BYTES = 16376
) (
   input  logic      clock,
   input  logic      reset,
   mfs_req_if.sink   req_chan,
   mfs_rsp_if.source rsp_chan
);
   import mfs_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   mfs_control u_control (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .status   (status),
      .cmd      (cmd)
   );

   mfs_datapath #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_type      (req_chan.req_type),
      .in_byte       (req_chan.in_byte),
      .out_ready     (rsp_chan.ready),
      .out_valid     (rsp_chan.valid),
      .frame_byte    (rsp_chan.frame_byte),
      .byte_valid    (rsp_chan.byte_valid),
      .frame_first   (rsp_chan.frame_first),
      .frame_last    (rsp_chan.frame_last),
      .frame_cut     (rsp_chan.frame_cut),
      .sample_rate   (rsp_chan.sample_rate),
      .channel_count (rsp_chan.channel_count),
      .frame_time    (rsp_chan.frame_time),
      .frame_length  (rsp_chan.frame_length),
      .run_last      (rsp_chan.run_last)
   );

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import mfs_pkg::*;

   localparam int MAX_LEN = 16376;
   localparam int TIMEOUT_NS = 8_000_000;
   localparam int DRAIN_CYCLES = 40;

   localparam logic BEAT_BYTE  = 1'b0;
   localparam logic BEAT_FLUSH = 1'b1;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_SYNC1,
      ST_HDR2,
      ST_HDR3,
      ST_BODY
   } parse_state_type;

   typedef struct packed {
      logic [7:0]  frame_byte;
      logic        byte_valid;
      logic        frame_first;
      logic        frame_last;
      logic        frame_cut;
      logic [15:0] sample_rate;
      logic [1:0]  channel_count;
      logic [31:0] frame_time;
      logic [13:0] frame_length;
      logic        run_last;
   } frame_beat_type;

   logic clock;
   logic reset;

   mfs_req_if req_bus();
   mfs_rsp_if rsp_bus();

   mp3_frame_splitter_unit #(
      .MAX_FRAME_BYTES(MAX_LEN)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Splitter state as the testbench tracks it.
   parse_state_type parse_st = ST_HUNT;
   logic [7:0]   hdr_hold [3];
   int           body_left = 0;
   logic [13:0]  cur_len = '0;
   logic [15:0]  cur_rate = '0;
   logic [1:0]   cur_chan = CHAN_STEREO;
   logic [31:0]  clock_ms = '0;
   logic [31:0]  cur_time = '0;

   frame_beat_type expected_beats [$];

   int error_count = 0;
   int items_sent = 0;
   int beats_checked = 0;
   int frames_seen = 0;
   int cuts_seen = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_left = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb: errors");
      $finish;
   end

   function automatic int kbps_of(input logic ver, input logic [1:0] row,
                                  input logic [3:0] idx);
      int r [16];
      case ({ver, row})
         3'b000, 3'b001: r = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0};
         3'b010:         r = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224,
                               256, 0};
         3'b100:         r = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256,
                               320, 0};
         3'b101:         r = '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320,
                               384, 0};
         default:        r = '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416,
                               448, 0};
      endcase
      return r[idx];
   endfunction

   function automatic int rate_of(input logic [7:0] h1, input logic [7:0] h2);
      int base;
      case (h2[3:2])
         2'd1:    base = 24000;
         2'd2:    base = 16000;
         default: base = 22050;
      endcase
      return h1[3] ? 2 * base : base;
   endfunction

   function automatic int frame_len_of(input logic [7:0] h1, input logic [7:0] h2);
      logic [1:0] layer;
      logic [1:0] row;
      int br;
      int rate;
      int pad;
      layer = h1[2:1];
      row = (layer == 2'd0) ? 2'd0 : layer - 2'd1;
      br = kbps_of(h1[3], row, h2[7:4]) * 1000;
      rate = rate_of(h1, h2);
      pad = int'(h2[1]);
      if (layer == LAYER_ONE) return ((12 * br) / rate + pad) * 4;
      return (144 * br) / rate + pad;
   endfunction

   function automatic frame_beat_type make_beat(input logic [7:0] b, input logic valid,
                                                input logic first, input logic last,
                                                input logic cut);
      frame_beat_type fb;
      fb.frame_byte = b;
      fb.byte_valid = valid;
      fb.frame_first = first;
      fb.frame_last = last;
      fb.frame_cut = cut;
      fb.sample_rate = cur_rate;
      fb.channel_count = cur_chan;
      fb.frame_time = cur_time;
      fb.frame_length = cur_len;
      fb.run_last = 1'b0;
      return fb;
   endfunction

   // Advances the tracked state by one accepted input beat and queues the beats it causes.
   task automatic predict_beats(input logic kind, input logic [7:0] b);
      frame_beat_type outb [4];
      int n;
      int len;
      int rate;
      n = 0;
      if (kind == BEAT_FLUSH) begin
         if (parse_st == ST_BODY) begin
            outb[0] = make_beat(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
            n = 1;
         end
         parse_st = ST_HUNT;
         body_left = 0;
      end else begin
         case (parse_st)
            ST_SYNC1: begin
               if ((b & SYNC_HI_MASK) == SYNC_HI_MASK) begin
                  hdr_hold[1] = b;
                  parse_st = ST_HDR2;
               end else begin
                  parse_st = ST_HUNT;
               end
            end
            ST_HDR2: begin
               hdr_hold[2] = b;
               parse_st = ST_HDR3;
            end
            ST_HDR3: begin
               len = frame_len_of(hdr_hold[1], hdr_hold[2]);
               parse_st = ST_HUNT;
               if (len >= HEADER_BYTES && len <= MAX_LEN) begin
                  rate = rate_of(hdr_hold[1], hdr_hold[2]);
                  cur_rate = 16'(rate);
                  cur_len = 14'(len);
                  cur_time = clock_ms;
                  clock_ms = clock_ms + 32'((2048000 + rate) / (2 * rate));
                  cur_chan = (b[7:6] == MODE_MONO) ? CHAN_MONO : CHAN_STEREO;
                  body_left = len - HEADER_BYTES;
                  for (int i = 0; i < 3; i++)
                     outb[i] = make_beat(hdr_hold[i], 1'b1, i == 0, 1'b0, 1'b0);
                  outb[3] = make_beat(b, 1'b1, 1'b0, body_left == 0, 1'b0);
                  n = 4;
                  if (body_left != 0) parse_st = ST_BODY;
               end
            end
            ST_BODY: begin
               outb[0] = make_beat(b, 1'b1, 1'b0, body_left == 1, 1'b0);
               n = 1;
               if (body_left > 0) body_left--;
               if (body_left == 0) parse_st = ST_HUNT;
            end
            default: begin
               if (b == SYNC_BYTE) begin
                  hdr_hold[0] = b;
                  parse_st = ST_SYNC1;
               end else begin
                  parse_st = ST_HUNT;
               end
            end
         endcase
      end
      if (n > 0) outb[n - 1].run_last = 1'b1;
      for (int i = 0; i < n; i++) expected_beats.push_back(outb[i]);
   endtask

   task automatic log_mismatch(input string msg);
      error_count++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         log_mismatch($sformatf("beat %0d %s got 0x%0h expected 0x%0h",
                                beats_checked, name, got, want));
   endtask

   // Entered at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(input logic kind, input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.in_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_beats(kind, b);
      items_sent++;
      @(negedge clock);
   endtask

   // Sends sync, three header bytes and a valid frame's body; a body cut short ends in a flush.
   task automatic send_frame(input logic [7:0] h1, input logic [7:0] h2,
                             input logic [7:0] h3, input int cut_at, output int sent);
      int len;
      int body;
      len = frame_len_of(h1, h2);
      send_beat(BEAT_BYTE, SYNC_BYTE);
      send_beat(BEAT_BYTE, h1);
      send_beat(BEAT_BYTE, h2);
      send_beat(BEAT_BYTE, h3);
      sent = HEADER_BYTES;
      if (len >= HEADER_BYTES && len <= MAX_LEN) begin
         body = (cut_at >= 0 && cut_at < len - HEADER_BYTES) ? cut_at : len - HEADER_BYTES;
         repeat (body) begin
            send_beat(BEAT_BYTE, 8'($urandom_range(0, 255)));
            sent++;
         end
         if (body < len - HEADER_BYTES) begin
            send_beat(BEAT_FLUSH, 8'($urandom_range(0, 255)));
            sent++;
         end
      end
   endtask

   task automatic random_header(output logic [7:0] h1, output logic [7:0] h2,
                                output logic [7:0] h3, input int cap);
      int len;
      do begin
         h1 = 8'($urandom_range(8'hF0, 8'hFF));
         h2 = 8'($urandom_range(0, 255));
         h3 = 8'($urandom_range(0, 255));
         len = frame_len_of(h1, h2);
      end while (len < HEADER_BYTES || len > cap);
   endtask

   task automatic test_hunt_and_sync;
      send_beat(BEAT_BYTE, 8'h00);
      send_beat(BEAT_FLUSH, 8'hFF);
      // A bad second sync byte drops the pair.
      send_beat(BEAT_BYTE, SYNC_BYTE);
      send_beat(BEAT_BYTE, 8'h7F);
      // A second 0xFF is a valid sync byte; the flush then drops the partial header.
      send_beat(BEAT_BYTE, SYNC_BYTE);
      send_beat(BEAT_BYTE, SYNC_BYTE);
      send_beat(BEAT_BYTE, 8'h10);
      send_beat(BEAT_FLUSH, 8'h00);
   endtask

   task automatic test_header_decode;
      int sent;
      // Free bitrate without padding gives a length below the minimum.
      send_frame(8'hF2, 8'h00, 8'h00, -1, sent);
      // Layer one with padding and a zero bitrate: header-only frame, reserved rate, mono.
      send_frame(8'hFF, 8'h0E, 8'hC0, -1, sent);
      // Bad bitrate index with padding, lowest sample rate.
      send_frame(8'hF7, 8'hFB, 8'h3F, -1, sent);
   endtask

   task automatic test_flush_cut;
      int sent;
      // Reserved layer code with the reserved rate code, cut after two body bytes.
      send_frame(8'hF0, 8'h1C, 8'h40, 2, sent);
   endtask

   task automatic test_input_stall;
      int sent;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_left = 400;
      // A 48-byte frame against a held-off receiver, so the block backs up into the input.
      send_frame(8'hF2, 8'h14, 8'h80, -1, sent);
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int budget);
      int start;
      int pick;
      int cut;
      int sent;
      logic [7:0] h1;
      logic [7:0] h2;
      logic [7:0] h3;
      logic [7:0] nb;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      start = items_sent;
      while (items_sent - start < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            random_header(h1, h2, h3, 72);
            cut = -1;
            if ($urandom_range(0, 9) == 0 && frame_len_of(h1, h2) > HEADER_BYTES)
               cut = $urandom_range(0, frame_len_of(h1, h2) - HEADER_BYTES - 1);
            send_frame(h1, h2, h3, cut, sent);
         end else if (pick < 85) begin
            case ($urandom_range(0, 2))
               0: begin
                  send_beat(BEAT_BYTE, SYNC_BYTE);
                  send_beat(BEAT_BYTE, 8'($urandom_range(0, 8'hEF)));
               end
               1: begin
                  send_beat(BEAT_BYTE, SYNC_BYTE);
                  send_beat(BEAT_BYTE, 8'($urandom_range(8'hF0, 8'hFF)));
                  if ($urandom_range(0, 1))
                     send_beat(BEAT_BYTE, 8'($urandom_range(0, 255)));
                  send_beat(BEAT_FLUSH, 8'($urandom_range(0, 255)));
               end
               default: begin
                  h1 = 8'($urandom_range(8'hF0, 8'hFF));
                  h2 = 8'($urandom_range(0, 15));
                  if ($urandom_range(0, 1)) h2 = h2 | 8'hF0;
                  h3 = 8'($urandom_range(0, 255));
                  send_frame(h1, h2, h3, -1, sent);
               end
            endcase
         end else begin
            repeat ($urandom_range(1, 4)) begin
               do nb = 8'($urandom_range(0, 255)); while (nb == SYNC_BYTE);
               send_beat(BEAT_BYTE, nb);
            end
            if ($urandom_range(0, 2) == 0) send_beat(BEAT_FLUSH, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Receiver: random stalls, plus a counted hold-off when a test asks for one.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      frame_beat_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_beats.size() == 0) begin
            log_mismatch($sformatf("unexpected beat, byte 0x%0h", rsp_bus.frame_byte));
         end else begin
            want = expected_beats.pop_front();
            compare_field("frame_byte", rsp_bus.frame_byte, want.frame_byte);
            compare_field("byte_valid", rsp_bus.byte_valid, want.byte_valid);
            compare_field("frame_first", rsp_bus.frame_first, want.frame_first);
            compare_field("frame_last", rsp_bus.frame_last, want.frame_last);
            compare_field("frame_cut", rsp_bus.frame_cut, want.frame_cut);
            compare_field("sample_rate", rsp_bus.sample_rate, want.sample_rate);
            compare_field("channel_count", rsp_bus.channel_count, want.channel_count);
            compare_field("frame_time", rsp_bus.frame_time, want.frame_time);
            compare_field("frame_length", rsp_bus.frame_length, want.frame_length);
            compare_field("run_last", rsp_bus.run_last, want.run_last);
            if (want.frame_first) frames_seen++;
            if (want.frame_cut) cuts_seen++;
         end
         beats_checked++;
      end
   end

   initial begin
      int waited;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.req_type = BEAT_BYTE;
      req_bus.in_byte = 8'h00;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_hunt_and_sync();
      test_header_decode();
      test_flush_cut();
      test_input_stall();
      test_random_traffic(0, 0, 85);
      test_random_traffic(87, 0, 85);
      test_random_traffic(0, 87, 85);
      test_random_traffic(37, 37, 85);

      req_bus.valid <= 1'b0;
      waited = 0;
      while (expected_beats.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_beats.size() != 0)
         log_mismatch($sformatf("%0d expected beats never arrived", expected_beats.size()));

      $display("Sent %0d input beats and checked %0d output beats over %0d frames (%0d cut).",
               items_sent, beats_checked, frames_seen, cuts_seen);
      $display("Covered sync hunting, header corners, flush cuts, a long hold-off and random %s",
               "traffic under gaps and stalls.");
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
